// ===== rtl/core/video_test_pattern_pixel_defines.svh =====
// assertion macros for the video test pattern pixel block
// used by the port checker, relies on clk and arst_n being in scope
`ifndef VIDEO_TEST_PATTERN_PIXEL_DEFINES_SVH
`define VIDEO_TEST_PATTERN_PIXEL_DEFINES_SVH

// same-cycle implication, off while in reset
`define VTP_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define VTP_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// holds at every edge while reset is asserted
`define VTP_CHECK_IN_RESET(lbl, cons, msg) \
	lbl: assert property (@(posedge clk) !arst_n |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vtp_pkg.sv =====
// shared types, constants and colour helpers for the test pattern pixel block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int PHASE_W = 6;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam int FRAME_WIDTH_RST = 240;
	localparam int FRAME_HEIGHT_RST = 240;
	localparam int NUM_BARS = 6;

	localparam logic [7:0] CHAN_FULL = 8'hFF;
	localparam logic [7:0] CHAN_NONE = 8'h00;

	typedef enum logic [1:0] {
		MODE_BARS = 2'd0,
		MODE_CHECKER = 2'd1,
		MODE_GRADIENT = 2'd2
	} mode_t;

	// rgb565 with the two bytes swapped
	function automatic logic [15:0] pack_swapped(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [15:0] w;
		begin
			w = {r[7:3], g[7:2], b[7:3]};
			return {w[7:0], w[15:8]};
		end
	endfunction

	function automatic logic [15:0] bar_color(input logic [2:0] idx);
		logic [15:0] c;
		begin
			case (idx)
				3'd0: c = pack_swapped(CHAN_NONE, CHAN_NONE, CHAN_NONE);
				3'd1: c = pack_swapped(CHAN_FULL, CHAN_NONE, CHAN_NONE);
				3'd2: c = pack_swapped(CHAN_NONE, CHAN_FULL, CHAN_NONE);
				3'd3: c = pack_swapped(CHAN_NONE, CHAN_NONE, CHAN_FULL);
				3'd4: c = pack_swapped(CHAN_FULL, CHAN_FULL, CHAN_NONE);
				3'd5: c = pack_swapped(CHAN_FULL, CHAN_NONE, CHAN_FULL);
				default: c = pack_swapped(CHAN_NONE, CHAN_NONE, CHAN_NONE);
			endcase
			return c;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vtp_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes in step
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module vtp_div_pipe #(
	parameter int LANES = 3,
	parameter int DVD_W = 18,
	parameter int DSR_W = 10,
	parameter int TAG_W = 7
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire logic [LANES-1:0][DVD_W-1:0]      dividend,
	input  wire logic [LANES-1:0][DSR_W-1:0]      divisor,
	input  wire logic [TAG_W-1:0]                 tag_in,
	output logic                                  out_valid,
	output logic [LANES-1:0][DVD_W-1:0]           quotient,
	output logic [TAG_W-1:0]                      tag_out
);

	logic [LANES-1:0][DSR_W-1:0] rem_s [DVD_W];
	logic [LANES-1:0][DVD_W-1:0] work_s [DVD_W];
	logic [TAG_W-1:0]            tag_s [DVD_W];
	logic [DVD_W-1:0]            valid_s;

	for (genvar k = 0; k < DVD_W; k++) begin : g_stage
		logic [LANES-1:0][DSR_W-1:0] rem_prev;
		logic [LANES-1:0][DVD_W-1:0] work_prev;
		logic [TAG_W-1:0]            tag_prev;
		logic                        valid_prev;
		logic [LANES-1:0][DSR_W-1:0] rem_next;
		logic [LANES-1:0][DVD_W-1:0] work_next;

		if (k == 0) begin : g_first
			assign rem_prev   = '0;
			assign work_prev  = dividend;
			assign tag_prev   = tag_in;
			assign valid_prev = in_valid;
		end else begin : g_rest
			assign rem_prev   = rem_s[k-1];
			assign work_prev  = work_s[k-1];
			assign tag_prev   = tag_s[k-1];
			assign valid_prev = valid_s[k-1];
		end

		// remaining dividend bits shift out at the top, quotient bits come in at the bottom
		always_comb begin
			logic [DSR_W:0] trial;
			logic           ge;
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_prev[l], work_prev[l][DVD_W-1]};
				ge = (trial >= {1'b0, divisor[l]});
				rem_next[l] = ge ? DSR_W'(trial - {1'b0, divisor[l]}) : trial[DSR_W-1:0];
				work_next[l] = {work_prev[l][DVD_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_next;
				work_s[k] <= work_next;
				tag_s[k]  <= tag_prev;
			end
		end
	end

	assign out_valid = valid_s[DVD_W-1];
	assign quotient  = work_s[DVD_W-1];
	assign tag_out   = tag_s[DVD_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/video_test_pattern_pixel.sv =====
// video test pattern pixel generator, top level
// depends on vtp_pkg and vtp_div_pipe
//
// One request on the input channel carries a pixel position and a frame phase;
// one request on the output channel returns that pixel's colour as rgb565 with
// its bytes swapped. Colour bars, checkerboard or gradient are chosen by
// pattern_mode, and frame_width / frame_height set the divisors. Registers are
// written over the cfg channel (index 0 mode, 1 width, 2 height), which is
// always ready; write them only while no pixel is in flight.
// The pipeline is COORD_BITS + 8 stages of the restoring divider, one quotient
// bit per stage, then a stage for the bar index multiply and the output
// register. One pixel is taken every cycle while the output is not stalled.
// The whole pipeline moves as one: when a result waits in the output register
// and out_ready is low, every stage holds and in_ready drops; nothing is lost
// or repeated. Asynchronous reset empties the pipeline and restores mode 0,
// width 240 and height 240.
`timescale 1ns / 1ps
`default_nettype none

module video_test_pattern_pixel #(
	parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [vtp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [COORD_BITS-1:0]             cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [COORD_BITS-1:0]             pixel_x,
	input  wire logic [COORD_BITS-1:0]             pixel_y,
	input  wire logic [vtp_pkg::PHASE_W-1:0]       frame_phase,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [15:0]                            pixel_color
);

	localparam int DVD_W = COORD_BITS + 8;
	localparam int TAG_W = vtp_pkg::PHASE_W + 1;
	localparam int LANES = 3;
	localparam int BAR_SHIFT = COORD_BITS + 3;
	localparam int PROD_W = 2 * COORD_BITS + 1;
	// ceil(2^(n+3) / 6): exact division by six for every n-bit value
	localparam logic [COORD_BITS:0] BAR_MAGIC =
		(COORD_BITS + 1)'(((2 ** BAR_SHIFT) + vtp_pkg::NUM_BARS - 1) / vtp_pkg::NUM_BARS);
	localparam logic [COORD_BITS-1:0] WIDTH_RST = COORD_BITS'(vtp_pkg::FRAME_WIDTH_RST);
	localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(vtp_pkg::FRAME_HEIGHT_RST);
	localparam logic [COORD_BITS-1:0] BAR_RST =
		COORD_BITS'(vtp_pkg::FRAME_WIDTH_RST / vtp_pkg::NUM_BARS);

	logic [1:0]            pattern_mode_q;
	logic [COORD_BITS-1:0] frame_width_q;
	logic [COORD_BITS-1:0] frame_height_q;
	logic [COORD_BITS-1:0] bar_len_q;

	logic [PROD_W-1:0]     cfg_prod;
	logic [COORD_BITS-1:0] bar_len_calc;
	logic                  cfg_we;
	logic                  adv;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// bar width is the frame width over six, at least one
	assign cfg_prod     = PROD_W'(cfg_data) * PROD_W'(BAR_MAGIC);
	assign bar_len_calc = COORD_BITS'(cfg_prod >> BAR_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q <= vtp_pkg::MODE_BARS;
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			bar_len_q      <= BAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vtp_pkg::CFG_MODE: begin
					pattern_mode_q <= cfg_data[1:0];
				end
				vtp_pkg::CFG_WIDTH: begin
					frame_width_q <= cfg_data;
					bar_len_q     <= (bar_len_calc == '0) ? COORD_BITS'(1) : bar_len_calc;
				end
				vtp_pkg::CFG_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline moves whenever the output register is free or being emptied
	logic out_valid_q;
	logic [15:0] pixel_color_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	logic [LANES-1:0][DVD_W-1:0]      div_dvd;
	logic [LANES-1:0][COORD_BITS-1:0] div_dsr;
	logic [TAG_W-1:0]                 div_tag_in;
	logic                             div_valid;
	logic [LANES-1:0][DVD_W-1:0]      div_quo;
	logic [TAG_W-1:0]                 div_tag;

	// lane 0: x*255/w, lane 1: y*255/h, lane 2: x/bar_len
	assign div_dvd[0] = {pixel_x, 8'b0} - DVD_W'(pixel_x);
	assign div_dvd[1] = {pixel_y, 8'b0} - DVD_W'(pixel_y);
	assign div_dvd[2] = DVD_W'(pixel_x);
	assign div_dsr[0] = frame_width_q;
	assign div_dsr[1] = frame_height_q;
	assign div_dsr[2] = bar_len_q;
	// checker cell parity is bit 3 of x xor bit 3 of y
	assign div_tag_in = {pixel_x[3] ^ pixel_y[3], frame_phase};

	vtp_div_pipe #(
		.LANES (LANES),
		.DVD_W (DVD_W),
		.DSR_W (COORD_BITS),
		.TAG_W (TAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (in_valid),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.tag_in    (div_tag_in),
		.out_valid (div_valid),
		.quotient  (div_quo),
		.tag_out   (div_tag)
	);

	logic                  valid_s1;
	logic [7:0]            red_s1;
	logic [7:0]            green_s1;
	logic [COORD_BITS-1:0] bar_quo_s1;
	logic [PROD_W-1:0]     bar_prod_s1;
	logic [TAG_W-1:0]      tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1      <= div_quo[0][7:0];
			green_s1    <= div_quo[1][7:0];
			bar_quo_s1  <= div_quo[2][COORD_BITS-1:0];
			bar_prod_s1 <= PROD_W'(div_quo[2][COORD_BITS-1:0]) * PROD_W'(BAR_MAGIC);
			tag_s1      <= div_tag;
		end
	end

	logic [COORD_BITS-1:0]      bar_div6;
	logic [COORD_BITS-1:0]      bar_rem;
	logic [7:0]                 red_eff;
	logic [7:0]                 green_eff;
	logic [7:0]                 blue_eff;
	logic [15:0]                color_next;

	always_comb begin
		bar_div6  = COORD_BITS'(bar_prod_s1 >> BAR_SHIFT);
		bar_rem   = bar_quo_s1 - COORD_BITS'({bar_div6, 2'b0}) - COORD_BITS'({bar_div6, 1'b0});
		// a zero divisor gives an all-ones quotient, so force the channel to zero
		red_eff   = (frame_width_q == '0) ? vtp_pkg::CHAN_NONE : red_s1;
		green_eff = (frame_height_q == '0) ? vtp_pkg::CHAN_NONE : green_s1;
		blue_eff  = {1'b1, tag_s1[vtp_pkg::PHASE_W-1:0], 1'b0};
		case (pattern_mode_q)
			vtp_pkg::MODE_BARS: begin
				color_next = vtp_pkg::bar_color(bar_rem[2:0]);
			end
			vtp_pkg::MODE_CHECKER: begin
				color_next = tag_s1[TAG_W-1]
					? vtp_pkg::pack_swapped(vtp_pkg::CHAN_FULL, vtp_pkg::CHAN_FULL,
						vtp_pkg::CHAN_FULL)
					: vtp_pkg::pack_swapped(vtp_pkg::CHAN_NONE, vtp_pkg::CHAN_NONE,
						vtp_pkg::CHAN_NONE);
			end
			vtp_pkg::MODE_GRADIENT: begin
				color_next = vtp_pkg::pack_swapped(red_eff, green_eff, blue_eff);
			end
			default: begin
				color_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_color_q <= color_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = pixel_color_q;

endmodule

`default_nettype wire

// ===== rtl/core/vtp_port_checker.sv =====
// port-level checks for the test pattern pixel block, bound to the top level
// depends on vtp_pkg and video_test_pattern_pixel_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "video_test_pattern_pixel_defines.svh"

module vtp_port_checker #(
	parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [COORD_BITS-1:0]             pixel_x,
	input wire logic [COORD_BITS-1:0]             pixel_y,
	input wire logic [vtp_pkg::PHASE_W-1:0]       frame_phase,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [15:0]                       pixel_color
);

	// a waiting result holds its colour until taken
	`VTP_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_color), "result dropped or changed while stalled")

	// a pending input request keeps its payload
	`VTP_CHECK_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(frame_phase), "input request changed before acceptance")

	// input side only stalls when a result is stuck at the output
	`VTP_CHECK(a_ready_link, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow the output stall")

	// no result is offered while reset is held
	`VTP_CHECK_IN_RESET(a_rst_empty, !out_valid, "result offered during reset")

endmodule

bind video_test_pattern_pixel vtp_port_checker #(
	.COORD_BITS (COORD_BITS)
) u_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.frame_phase (frame_phase),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_color (pixel_color)
);

`default_nettype wire

// ===== test/video_test_pattern_pixel_checker.sv =====
// colour checker for the video test pattern pixel block: tracks register writes,
// predicts each pixel's colour and compares it with what the block returns
// depends on vtp_pkg for the register indexes, mode codes and reset values
`timescale 1ns / 1ps

module video_test_pattern_pixel_checker #(
	parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [vtp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]           cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [COORD_BITS-1:0]           pixel_x,
	input  logic [COORD_BITS-1:0]           pixel_y,
	input  logic [vtp_pkg::PHASE_W-1:0]     frame_phase,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [15:0]                     pixel_color,
	output int                              fail_count,
	output int                              colors_in_flight,
	output int                              colors_seen
);
	import vtp_pkg::*;

	localparam int CELL_SHIFT = 3;
	localparam int GRAD_SCALE = 255;
	localparam int BLUE_BASE = 128;
	localparam int CHAN_MASK = 255;

	// 24-bit rgb of each bar, index 0 (black) in the low bits
	localparam logic [5:0][23:0] BAR_RGB = {
		24'hFF00FF, 24'hFFFF00, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h000000
	};

	logic [1:0]   cur_mode;
	int unsigned  cur_width;
	int unsigned  cur_height;
	logic [15:0]  awaited_colors[$];
	logic [15:0]  expected;
	int           fails;
	int           seen;

	function automatic logic [15:0] swap565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [15:0] rgb;
		rgb = {r[7:3], g[7:2], b[7:3]};
		return {rgb[7:0], rgb[15:8]};
	endfunction

	function automatic logic [15:0] pattern_color(input logic [1:0] mode, input int unsigned w,
			input int unsigned h, input int unsigned x, input int unsigned y,
			input int unsigned phase);
		int unsigned bar_w;
		int unsigned bar;
		int unsigned red;
		int unsigned green;
		int unsigned blue;
		logic [15:0] c;
		c = '0;
		case (mode)
			MODE_BARS: begin
				bar_w = w / NUM_BARS;
				// frames narrower than six pixels fall back to one-pixel bars
				if (bar_w == 0)
					bar_w = 1;
				bar = (x / bar_w) % NUM_BARS;
				c = swap565(BAR_RGB[bar][23:16], BAR_RGB[bar][15:8], BAR_RGB[bar][7:0]);
			end
			MODE_CHECKER: begin
				if ((((x >> CELL_SHIFT) + (y >> CELL_SHIFT)) & 1) != 0)
					c = swap565(CHAN_FULL, CHAN_FULL, CHAN_FULL);
				else
					c = swap565(CHAN_NONE, CHAN_NONE, CHAN_NONE);
			end
			MODE_GRADIENT: begin
				// zero divisor gives a dark channel; large quotients wrap to 8 bits
				red = (w != 0) ? ((x * GRAD_SCALE) / w) & CHAN_MASK : 0;
				green = (h != 0) ? ((y * GRAD_SCALE) / h) & CHAN_MASK : 0;
				blue = BLUE_BASE + 2 * phase;
				c = swap565(red[7:0], green[7:0], blue[7:0]);
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_BARS;
			cur_width = FRAME_WIDTH_RST;
			cur_height = FRAME_HEIGHT_RST;
			awaited_colors.delete();
			fails = 0;
			seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: cur_mode = cfg_data[1:0];
					CFG_WIDTH: cur_width = cfg_data;
					CFG_HEIGHT: cur_height = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen++;
				if (awaited_colors.size() == 0) begin
					fails++;
					$error("pixel_color with no request outstanding: expected none, actual %h",
						pixel_color);
				end else begin
					expected = awaited_colors.pop_front();
					if (pixel_color !== expected) begin
						fails++;
						$error("pixel_color mismatch: expected %h, actual %h", expected,
							pixel_color);
					end
				end
			end
			if (in_valid && in_ready)
				awaited_colors.push_back(pattern_color(cur_mode, cur_width, cur_height,
					pixel_x, pixel_y, frame_phase));
		end
		fail_count <= fails;
		colors_in_flight <= awaited_colors.size();
		colors_seen <= seen;
	end

endmodule

// ===== test/video_test_pattern_pixel_tb.sv =====
// top of the video test pattern pixel testbench: clock, reset, register writes,
// pixel requests with random idling, and the final verdict
// depends on vtp_pkg, video_test_pattern_pixel and video_test_pattern_pixel_checker
`timescale 1ns / 1ps

module video_test_pattern_pixel_tb;
	import vtp_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int LATENCY = COORD_BITS + 10;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int SETTINGS_COUNT = 36;
	localparam int PIXELS_PER_SETTING = 52;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] MODE_UNDEFINED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b1;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [COORD_BITS-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [COORD_BITS-1:0]  pixel_x = '0;
	logic [COORD_BITS-1:0]  pixel_y = '0;
	logic [PHASE_W-1:0]     frame_phase = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [15:0]            pixel_color;

	int fail_count;
	int colors_in_flight;
	int colors_seen;
	int send_idle_pct = 20;
	int recv_idle_pct = 65;
	int cycles = 0;
	int settings_used = 0;
	int pixels_sent = 0;
	int unsigned frame_w = FRAME_WIDTH_RST;
	int unsigned frame_h = FRAME_HEIGHT_RST;

	video_test_pattern_pixel #(.COORD_BITS(COORD_BITS)) u_dut (.*);

	video_test_pattern_pixel_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("video_test_pattern_pixel verification failed");
			$finish;
		end
	end

	// leaves cfg_valid high so that back-to-back writes need no gap
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[COORD_BITS-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(input logic [1:0] mode, input int unsigned w,
			input int unsigned h);
		// upper data bits of the mode write are junk and must be ignored
		write_reg(CFG_MODE, ($urandom_range(255) << 2) | mode);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		cfg_valid <= 1'b0;
		frame_w = w;
		frame_h = h;
		settings_used++;
	endtask

	task automatic send_pixel(input int unsigned x, input int unsigned y,
			input int unsigned phase);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x[COORD_BITS-1:0];
		pixel_y <= y[COORD_BITS-1:0];
		frame_phase <= phase[PHASE_W-1:0];
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	// every request returns a colour, so an empty queue means the pipe is empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (colors_in_flight != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned pick;
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		logic [1:0] mode;

		// falling edge at time zero so the asynchronous reset takes hold at once
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a write to the unused index must leave the reset values alone
		write_reg(CFG_SPARE, 0);
		cfg_valid <= 1'b0;
		send_pixel(0, 0, 0);
		send_pixel(39, 5, 0);
		send_pixel(40, 0, 0);
		send_pixel(239, 239, 63);
		send_pixel(COORD_MAX, COORD_MAX, 63);

		wait_idle();
		apply_config(MODE_CHECKER, FRAME_WIDTH_RST, FRAME_HEIGHT_RST);
		send_pixel(0, 0, 0);
		send_pixel(8, 0, 0);
		send_pixel(7, 7, 0);
		send_pixel(8, 8, 0);
		send_pixel(COORD_MAX, COORD_MAX, 0);
		send_pixel(COORD_MAX, 0, 0);

		wait_idle();
		apply_config(MODE_GRADIENT, COORD_MAX, COORD_MAX);
		send_pixel(COORD_MAX, COORD_MAX, 63);
		send_pixel(0, 0, 0);
		send_pixel(512, 300, 32);

		// zero divisors
		wait_idle();
		apply_config(MODE_GRADIENT, 0, 0);
		send_pixel(100, 200, 17);

		// quotient far above 255 wraps
		wait_idle();
		apply_config(MODE_GRADIENT, 1, 1);
		send_pixel(COORD_MAX, 3, 1);

		// narrow frame, bars one pixel wide
		wait_idle();
		apply_config(MODE_BARS, 3, 0);
		send_pixel(COORD_MAX, 0, 0);
		send_pixel(5, 0, 0);

		wait_idle();
		apply_config(MODE_UNDEFINED, FRAME_WIDTH_RST, FRAME_HEIGHT_RST);
		send_pixel(10, 10, 10);

		for (int s = 0; s < SETTINGS_COUNT; s++) begin
			case (s * 3 / SETTINGS_COUNT)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			wait_idle();
			pick = $urandom_range(9);
			mode = (pick == 9) ? MODE_UNDEFINED : 2'(pick % 3);
			case (s % 6)
				0: begin
					w = COORD_MAX;
					h = COORD_MAX;
				end
				1: begin
					w = 6;
					h = 1;
				end
				2: begin
					w = $urandom_range(5);
					h = $urandom_range(1);
				end
				default: begin
					w = $urandom_range(COORD_MAX, 6);
					h = $urandom_range(COORD_MAX, 1);
				end
			endcase
			apply_config(mode, w, h);
			repeat (PIXELS_PER_SETTING) begin
				// mostly pixels inside the frame, some anywhere in the coordinate range
				if ($urandom_range(4) == 0 || frame_w == 0 || frame_h == 0) begin
					x = $urandom_range(COORD_MAX);
					y = $urandom_range(COORD_MAX);
				end else begin
					x = $urandom_range(frame_w - 1);
					y = $urandom_range(frame_h - 1);
				end
				send_pixel(x, y, $urandom_range(63));
			end
		end

		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);
		$display("covered %0d pixel requests under %0d register settings, %0d colours compared",
			pixels_sent, settings_used, colors_seen);
		$display("bars, checkerboard, gradient and undefined mode, with zero, narrow and full frames");
		if (fail_count == 0 && colors_in_flight == 0)
			$display("video_test_pattern_pixel verification clean");
		else
			$display("video_test_pattern_pixel verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/vtp_pkg.sv
rtl/core/vtp_div_pipe.sv
rtl/core/video_test_pattern_pixel.sv
rtl/core/vtp_port_checker.sv
test/video_test_pattern_pixel_checker.sv
test/video_test_pattern_pixel_tb.sv
